>>> hdl/mpv_pkg.sv
// Shared types and constants for the marker patch verifier.
`timescale 1ns / 1ps

package mpv_pkg;

  // Width of the patch dimension fields on the input port
  localparam int unsigned DIM_IN_W = 11;

  // Width of a pixel beat
  localparam int unsigned PIXEL_W = 8;

  // Pixel value that reads as white; anything else is dark
  localparam logic [PIXEL_W-1:0] WHITE_LEVEL = 8'hFF;

  // Per-pixel classification handed from the locate stage to the tally stage
  typedef struct packed {
    logic white;
    logic centre;
    logic last;
  } mpv_flags_t;

endpackage

>>> hdl/marker_patch_verifier.sv
// Top level of the marker patch verifier.
//
// Pixels of one binarized, rectified patch stream in on the input channel in
// row-major order, one beat per pixel, with the patch width and height on
// every beat and last_pixel set on the final one. The block tracks column
// and row itself, counts white (255) and dark pixels over the whole patch and
// inside the central 40%..60% window, and sends one verdict beat
// (is_marker, center_passed) on the output channel per patch.
// Throughput: one pixel beat per clock while in_stall is low; the path is an
// input register, a classify register, a count snapshot and a result
// register, and a patch's verdict moves through them in that order.
// Non-last pixels produce no output beat.
// Reset (rst, synchronous) empties all stages and clears position and
// counters; in_stall is low once reset has ended.
// When the receiver stalls, the verdict is held and the snapshot stage and
// the counters keep absorbing pixels; input stalls only once a further
// last pixel finds no room ahead of it.
`timescale 1ns / 1ps

module marker_patch_verifier import mpv_pkg::*; #(
  parameter int unsigned MAX_PATCH_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIXEL_W-1:0]  pixel_value,
  input  logic [DIM_IN_W-1:0] patch_width,
  input  logic [DIM_IN_W-1:0] patch_height,
  input  logic                last_pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_marker,
  output logic                center_passed
);

  localparam int unsigned COUNT_W = 2 * $clog2(MAX_PATCH_DIM) + 1;

  logic               flag_valid;
  logic               flag_ready;
  mpv_flags_t         flag;
  logic               snap_valid;
  logic               snap_ready;
  logic [COUNT_W-1:0] snap_center_white;
  logic [COUNT_W-1:0] snap_center_dark;
  logic [COUNT_W-1:0] snap_total_white;
  logic [COUNT_W-1:0] snap_total_dark;

  // Position tracking and pixel classification
  mpv_locate #(
    .MAX_PATCH_DIM (MAX_PATCH_DIM)
  ) u_locate (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .patch_width  (patch_width),
    .patch_height (patch_height),
    .last_pixel   (last_pixel),
    .flag_valid   (flag_valid),
    .flag         (flag),
    .flag_ready   (flag_ready)
  );

  // Counters and end-of-patch snapshot
  mpv_tally #(
    .MAX_PATCH_DIM (MAX_PATCH_DIM)
  ) u_tally (
    .clk               (clk),
    .rst               (rst),
    .flag_valid        (flag_valid),
    .flag              (flag),
    .flag_ready        (flag_ready),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap_center_white (snap_center_white),
    .snap_center_dark  (snap_center_dark),
    .snap_total_white  (snap_total_white),
    .snap_total_dark   (snap_total_dark)
  );

  // Verdict and result register
  mpv_judge #(
    .MAX_PATCH_DIM (MAX_PATCH_DIM)
  ) u_judge (
    .clk               (clk),
    .rst               (rst),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap_center_white (snap_center_white),
    .snap_center_dark  (snap_center_dark),
    .snap_total_white  (snap_total_white),
    .snap_total_dark   (snap_total_dark),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .is_marker         (is_marker),
    .center_passed     (center_passed)
  );

endmodule

>>> hdl/mpv_locate.sv
// Input register, raster position tracking and per-pixel classification.
`timescale 1ns / 1ps

module mpv_locate import mpv_pkg::*; #(
  parameter int unsigned MAX_PATCH_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIXEL_W-1:0]  pixel_value,
  input  logic [DIM_IN_W-1:0] patch_width,
  input  logic [DIM_IN_W-1:0] patch_height,
  input  logic                last_pixel,
  output logic                flag_valid,
  output mpv_flags_t          flag,
  input  logic                flag_ready
);

  localparam int unsigned POS_W = $clog2(MAX_PATCH_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_PATCH_DIM + 1);
  localparam int unsigned CMP_W = (DIM_W > DIM_IN_W) ? DIM_W : DIM_IN_W;
  localparam int unsigned E_W   = $clog2(10 * MAX_PATCH_DIM + 6);
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_PATCH_DIM);
  localparam logic [POS_W-1:0] ROW_LIMIT = POS_W'(MAX_PATCH_DIM - 1);

  // Input beat register
  logic                s1_valid;
  logic [PIXEL_W-1:0]  s1_pixel;
  logic [DIM_IN_W-1:0] s1_width;
  logic [DIM_IN_W-1:0] s1_height;
  logic                s1_last;

  // Raster position of the pixel held in the input register
  logic [POS_W-1:0] column_position;
  logic [POS_W-1:0] row_position;
  logic [POS_W-1:0] column_position_next;
  logic [POS_W-1:0] row_position_next;

  logic             s1_ready;
  logic             s1_fire;
  logic [DIM_W-1:0] w_dim;
  logic [DIM_W-1:0] h_dim;
  logic [DIM_W-1:0] column_plus1;
  mpv_flags_t       flag_next;

  // Zero reads as one, oversize reads as the maximum dimension
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_IN_W-1:0] d);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] res;
    ext = CMP_W'(d);
    if (ext == '0) begin
      res = CMP_W'(1);
    end else if (ext > MAX_DIM_C) begin
      res = MAX_DIM_C;
    end else begin
      res = ext;
    end
    return res[DIM_W-1:0];
  endfunction

  // pos in [round(0.4*dim), round(0.6*dim)) without a divide:
  // pos >= (4d+5)/10  <=>  10*(pos+1) > 4d+5
  // pos <  (6d+5)/10  <=>  10*(pos+1) <= 6d+5
  function automatic logic in_window(input logic [POS_W-1:0] pos,
                                     input logic [DIM_W-1:0] dim);
    logic [E_W-1:0] p1;
    logic [E_W-1:0] d;
    logic [E_W-1:0] ten_p;
    logic [E_W-1:0] lo_b;
    logic [E_W-1:0] hi_b;
    p1    = E_W'(pos) + E_W'(1);
    d     = E_W'(dim);
    ten_p = (p1 << 3) + (p1 << 1);
    lo_b  = (d << 2) + E_W'(5);
    hi_b  = (d << 2) + (d << 1) + E_W'(5);
    return (ten_p > lo_b) && (ten_p <= hi_b);
  endfunction

  // Handshake: the input register frees up when its beat moves on
  assign s1_ready = !s1_valid || !flag_valid || flag_ready;
  assign s1_fire  = s1_valid && (!flag_valid || flag_ready);
  assign in_stall = !s1_ready;

  assign w_dim        = clamp_dim(s1_width);
  assign h_dim        = clamp_dim(s1_height);
  assign column_plus1 = DIM_W'(column_position) + DIM_W'(1);

  // Classify the held pixel
  always_comb begin
    flag_next.white  = (s1_pixel == WHITE_LEVEL);
    flag_next.centre = in_window(column_position, w_dim) &&
                       in_window(row_position, h_dim);
    flag_next.last   = s1_last;
  end

  // Advance the raster position; the last pixel restarts it
  always_comb begin
    column_position_next = column_position;
    row_position_next    = row_position;
    if (s1_last) begin
      column_position_next = '0;
      row_position_next    = '0;
    end else if (column_plus1 >= w_dim) begin
      column_position_next = '0;
      if (row_position < ROW_LIMIT) begin
        row_position_next = row_position + POS_W'(1);
      end
    end else begin
      column_position_next = column_plus1[POS_W-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_pixel  <= pixel_value;
      s1_width  <= patch_width;
      s1_height <= patch_height;
      s1_last   <= last_pixel;
    end
  end

  // Position state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (s1_fire) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

  // Flag register
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_valid <= 1'b0;
    end else if (!flag_valid || flag_ready) begin
      flag_valid <= s1_valid;
    end
    if (s1_fire) begin
      flag <= flag_next;
    end
  end

endmodule

>>> hdl/mpv_tally.sv
// Saturating white/dark counters and the end-of-patch count snapshot.
`timescale 1ns / 1ps

module mpv_tally import mpv_pkg::*; #(
  parameter int unsigned MAX_PATCH_DIM = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 flag_valid,
  input  mpv_flags_t                           flag,
  output logic                                 flag_ready,
  output logic                                 snap_valid,
  input  logic                                 snap_ready,
  output logic [2*$clog2(MAX_PATCH_DIM):0]     snap_center_white,
  output logic [2*$clog2(MAX_PATCH_DIM):0]     snap_center_dark,
  output logic [2*$clog2(MAX_PATCH_DIM):0]     snap_total_white,
  output logic [2*$clog2(MAX_PATCH_DIM):0]     snap_total_dark
);

  localparam int unsigned COUNT_W = 2 * $clog2(MAX_PATCH_DIM) + 1;

  logic [COUNT_W-1:0] center_white_count;
  logic [COUNT_W-1:0] center_dark_count;
  logic [COUNT_W-1:0] total_white_count;
  logic [COUNT_W-1:0] total_dark_count;
  logic [COUNT_W-1:0] center_white_count_next;
  logic [COUNT_W-1:0] center_dark_count_next;
  logic [COUNT_W-1:0] total_white_count_next;
  logic [COUNT_W-1:0] total_dark_count_next;
  logic               flag_fire;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                 input logic             en);
    if (en && (c != '1)) begin
      return c + COUNT_W'(1);
    end
    return c;
  endfunction

  // A non-last beat always drains; a last beat needs room in the snapshot
  assign flag_ready = !flag.last || !snap_valid || snap_ready;
  assign flag_fire  = flag_valid && flag_ready;

  // Counts including the current pixel
  always_comb begin
    center_white_count_next = sat_inc(center_white_count, flag.centre && flag.white);
    center_dark_count_next  = sat_inc(center_dark_count, flag.centre && !flag.white);
    total_white_count_next  = sat_inc(total_white_count, flag.white);
    total_dark_count_next   = sat_inc(total_dark_count, !flag.white);
  end

  // Running counters; cleared after the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      center_white_count <= '0;
      center_dark_count  <= '0;
      total_white_count  <= '0;
      total_dark_count   <= '0;
    end else if (flag_fire) begin
      if (flag.last) begin
        center_white_count <= '0;
        center_dark_count  <= '0;
        total_white_count  <= '0;
        total_dark_count   <= '0;
      end else begin
        center_white_count <= center_white_count_next;
        center_dark_count  <= center_dark_count_next;
        total_white_count  <= total_white_count_next;
        total_dark_count   <= total_dark_count_next;
      end
    end
  end

  // Snapshot of the final counts of one patch
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (flag_fire && flag.last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (flag_fire && flag.last) begin
      snap_center_white <= center_white_count_next;
      snap_center_dark  <= center_dark_count_next;
      snap_total_white  <= total_white_count_next;
      snap_total_dark   <= total_dark_count_next;
    end
  end

endmodule

>>> hdl/mpv_judge.sv
// Verdict compares and the result register.
`timescale 1ns / 1ps

module mpv_judge import mpv_pkg::*; #(
  parameter int unsigned MAX_PATCH_DIM = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             snap_valid,
  output logic                             snap_ready,
  input  logic [2*$clog2(MAX_PATCH_DIM):0] snap_center_white,
  input  logic [2*$clog2(MAX_PATCH_DIM):0] snap_center_dark,
  input  logic [2*$clog2(MAX_PATCH_DIM):0] snap_total_white,
  input  logic [2*$clog2(MAX_PATCH_DIM):0] snap_total_dark,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_marker,
  output logic                             center_passed
);

  localparam int unsigned COUNT_W = 2 * $clog2(MAX_PATCH_DIM) + 1;
  localparam int unsigned TEN_W   = COUNT_W + 4;
  localparam int unsigned SUM_W   = COUNT_W + 1;

  logic [TEN_W-1:0] dark_p1;
  logic [TEN_W-1:0] dark_scaled;
  logic [SUM_W-1:0] white_p1;
  logic             centre_ok;
  logic             marker_ok;

  // Centre passes when 10*(1+dark) < white; marker also needs dark > white+1
  always_comb begin
    dark_p1     = TEN_W'(snap_center_dark) + TEN_W'(1);
    dark_scaled = (dark_p1 << 3) + (dark_p1 << 1);
    white_p1    = SUM_W'(snap_total_white) + SUM_W'(1);
    centre_ok   = dark_scaled < TEN_W'(snap_center_white);
    marker_ok   = centre_ok && (SUM_W'(snap_total_dark) > white_p1);
  end

  assign snap_ready = !out_valid || !out_stall;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_ready && snap_valid) begin
      is_marker     <= marker_ok;
      center_passed <= centre_ok;
    end
  end

endmodule

>>> verif/marker_patch_verifier_tb.sv
// Self-checking testbench for the marker patch verifier: patch pixel beats in, verdicts checked.
`timescale 1ns / 1ps

module marker_patch_verifier_tb;
  import mpv_pkg::*;

  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned COUNT_W      = 21;
  localparam int unsigned COUNT_SAT    = (1 << COUNT_W) - 1;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RAND_PIXELS  = 1300;
  localparam int unsigned RAND_PATCHES = 30;

  typedef enum int {
    FILL_RANDOM,
    FILL_MARKER,
    FILL_IDEAL,
    FILL_WHITE,
    FILL_DARK
  } fill_style_t;

  typedef struct {
    logic [PIXEL_W-1:0]  pix;
    logic [DIM_IN_W-1:0] w;
    logic [DIM_IN_W-1:0] h;
    logic                last;
  } pixel_beat_t;

  typedef struct {
    logic marker;
    logic centre;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PIXEL_W-1:0]  pixel_value = '0;
  logic [DIM_IN_W-1:0] patch_width = '0;
  logic [DIM_IN_W-1:0] patch_height = '0;
  logic                last_pixel = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                is_marker;
  logic                center_passed;

  marker_patch_verifier dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .patch_width  (patch_width),
    .patch_height (patch_height),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_marker    (is_marker),
    .center_passed(center_passed)
  );

  always #2 clk = ~clk;

  // Pending pixel beats and expected verdicts
  pixel_beat_t pixel_q[$];
  verdict_t    verdict_q[$];

  int unsigned planned_pixels = 0;
  int unsigned planned_patches = 0;
  int unsigned pixels_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned error_count = 0;
  logic        in_beat_taken = 1'b0;

  // Idle pattern state
  int unsigned calm_left = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Patch tally state
  int unsigned col_pos, row_pos;
  int unsigned ctr_white, ctr_dark, all_white, all_dark;

  function automatic int unsigned clamp_dim(logic [DIM_IN_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return 32'(d);
  endfunction

  // Central window: round(0.4*N) .. round(0.6*N)-1
  function automatic bit in_window(int unsigned pos, int unsigned dim);
    int unsigned lo, hi;
    lo = (4 * dim + 5) / 10;
    hi = (6 * dim + 5) / 10;
    return (pos >= lo) && (pos < hi);
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c >= COUNT_SAT) ? c : c + 1;
  endfunction

  task automatic clear_counts();
    col_pos   = 0;
    row_pos   = 0;
    ctr_white = 0;
    ctr_dark  = 0;
    all_white = 0;
    all_dark  = 0;
  endtask

  // Count one accepted pixel; queue a verdict on the last one
  task automatic tally_pixel(input pixel_beat_t b);
    int unsigned w, h;
    bit          white;
    verdict_t    v;
    w = clamp_dim(b.w);
    h = clamp_dim(b.h);
    white = (b.pix == WHITE_LEVEL);
    if (in_window(col_pos, w) && in_window(row_pos, h)) begin
      if (white) ctr_white = bump(ctr_white);
      else ctr_dark = bump(ctr_dark);
    end
    if (white) all_white = bump(all_white);
    else all_dark = bump(all_dark);
    if (b.last) begin
      v.centre = (10 * (1 + ctr_dark)) < ctr_white;
      v.marker = v.centre && (all_dark > all_white + 1);
      verdict_q.insert(verdict_q.size(), v);
      clear_counts();
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < MAX_DIM - 1) row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      calm_left = 200;
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel(fill_style_t s, bit centre);
    int unsigned r;
    r = $urandom_range(0, 99);
    unique case (s)
      FILL_WHITE: begin
        return WHITE_LEVEL;
      end
      FILL_DARK: begin
        return PIXEL_W'($urandom_range(0, 254));
      end
      FILL_IDEAL: begin
        return centre ? WHITE_LEVEL : '0;
      end
      FILL_MARKER: begin
        if (centre) return (r < 96) ? WHITE_LEVEL : PIXEL_W'($urandom_range(0, 254));
        return (r < 85) ? PIXEL_W'($urandom_range(0, 254)) : WHITE_LEVEL;
      end
      default: begin
        if (r < 45) return WHITE_LEVEL;
        if (r < 70) return '0;
        return PIXEL_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic push_beat(input logic [PIXEL_W-1:0] pix, input int unsigned w,
                           input int unsigned h, input bit last);
    pixel_beat_t b;
    b.pix  = pix;
    b.w    = DIM_IN_W'(w);
    b.h    = DIM_IN_W'(h);
    b.last = last;
    pixel_q.insert(pixel_q.size(), b);
    planned_pixels++;
    if (last) planned_patches++;
  endtask

  // n pixels of one patch; content shaped by where the pixel lands
  task automatic add_patch(input int unsigned w, input int unsigned h, input int unsigned n,
                           input fill_style_t s, input bit with_last);
    int unsigned wc, hc, c, r;
    wc = clamp_dim(DIM_IN_W'(w));
    hc = clamp_dim(DIM_IN_W'(h));
    for (int unsigned i = 0; i < n; i++) begin
      c = i % wc;
      r = i / wc;
      if (r > MAX_DIM - 1) r = MAX_DIM - 1;
      push_beat(pick_pixel(s, in_window(c, wc) && in_window(r, hc)), w, h,
                with_last && (i == n - 1));
    end
  endtask

  // Driver: next beat once the current one is taken, payload held while stalled
  always @(negedge clk) begin
    pixel_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        b = pixel_q.pop_front();
        pixel_value  <= b.pix;
        patch_width  <= b.w;
        patch_height <= b.h;
        last_pixel   <= b.last;
        in_valid     <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    logic stall_next;
    if (rst) begin
      stall_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (!hold_done && verdicts_seen >= 5) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      stall_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else begin
      stall_left = pick_gap();
      stall_next = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
    out_stall <= stall_next;
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    pixel_beat_t b;
    verdict_t    exp_v;
    if (rst) begin
      clear_counts();
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        b.pix  = pixel_value;
        b.w    = patch_width;
        b.h    = patch_height;
        b.last = last_pixel;
        tally_pixel(b);
        pixels_taken++;
      end
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict beat with none expected");
        end else begin
          exp_v = verdict_q.pop_front();
          if (is_marker !== exp_v.marker)
            report_mismatch($sformatf("verdict %0d: is_marker %b, expected %b",
                                      verdicts_seen, is_marker, exp_v.marker));
          if (center_passed !== exp_v.centre)
            report_mismatch($sformatf("verdict %0d: center_passed %b, expected %b",
                                      verdicts_seen, center_passed, exp_v.centre));
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned r, w, h, n;

    // Directed: tiny, zero and oversized dimensions, clean marker, flat patches
    add_patch(1, 1, 1, FILL_WHITE, 1'b1);
    add_patch(0, 0, 3, FILL_DARK, 1'b1);
    add_patch(20, 13, 260, FILL_IDEAL, 1'b1);
    add_patch(20, 13, 260, FILL_WHITE, 1'b1);
    add_patch(6, 6, 36, FILL_DARK, 1'b1);
    add_patch(2047, 2047, 20, FILL_RANDOM, 1'b1);
    add_patch(1024, 1024, 10, FILL_RANDOM, 1'b1);
    add_patch(1025, 0, 6, FILL_RANDOM, 1'b1);
    // Dimensions that change from pixel to pixel
    for (int unsigned i = 0; i < 30; i++)
      push_beat(pick_pixel(FILL_RANDOM, 1'b0), 6 + i % 5, 10 - i % 3, i == 29);

    // Random: mostly well-formed patches, some broken sequences and noise
    while (planned_pixels < RAND_PIXELS || planned_patches < RAND_PATCHES) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        n = w * h;
        if ($urandom_range(0, 9) < 3) n = n + $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0 && n > 2) n = n - 2;
        add_patch(w, h, n, FILL_RANDOM, 1'b1);
      end else if (r < 70) begin
        w = $urandom_range(18, 22);
        h = $urandom_range(18, 22);
        add_patch(w, h, w * h, FILL_MARKER, 1'b1);
      end else begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 2047);
        add_patch(w, h, $urandom_range(1, 20),
                  fill_style_t'($urandom_range(0, 4)), $urandom_range(0, 9) < 7);
      end
    end
    // Close any patch left open by noise
    add_patch(4, 4, 1, FILL_RANDOM, 1'b1);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pixels_taken != planned_pixels || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
